@@ src/psd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the phase-shift demodulator.
package psd_pkg;

    // Phase resolution of the result: 2**PHASE_BITS equals one full turn.
    localparam int PHASE_BITS = 16;

    // Datapath widths and pipeline depths.
    localparam int CORDIC_W = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS = 8;
    localparam int SQRT_TOP_BIT = 14;

    // round(sqrt(3) * 2**16).
    localparam logic signed [CORDIC_W-1:0] SQRT3_Q16 = CORDIC_W'(113512);

    // Largest squared magnitude whose rounded root still fits in 8 bits.
    localparam logic [18:0] MAG_SAT_LIMIT = 19'd65280;

    localparam logic [31:0] ANG_HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] PHASE_HALF_LSB = 32'd1 << (31 - PHASE_BITS);

    // Register map.
    localparam int PADDR_W = 3;
    localparam logic REG_IDX_STEP_MODE = 1'b0;

    localparam logic MODE_THREE_STEP = 1'b0;
    localparam logic MODE_FOUR_STEP = 1'b1;

    typedef struct packed {
        logic [7:0] sample_a;
        logic [7:0] sample_b;
        logic [7:0] sample_c;
        logic [7:0] sample_d;
    } psd_sample_t;

    typedef struct packed {
        logic [15:0] wrapped_phase;
        logic [7:0]  modulation;
    } psd_result_t;

    // One pixel in flight through the rotation and root stages.
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [31:0]                ang;
        logic [15:0]                rem;
        logic [16:0]                root;
        logic                       sat;
        logic                       zero;
    } psd_token_t;

    // atan(2**-i) as a fraction of a turn in units of 2**-32, rounded.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/psd_front.sv @@
`timescale 1ns / 1ps
// Front end: quadrature pair, scaling, squared magnitude and half-turn pre-rotation.
module psd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  sample_valid,
    input  psd_pkg::psd_sample_t  samples,
    input  logic                  step_mode,
    output logic                  tok_valid,
    output psd_pkg::psd_token_t   tok
);
    import psd_pkg::*;

    // Stage A: differences.
    logic                 a_valid_reg;
    logic signed [9:0]    a_xi_reg, a_xi_next;
    logic signed [8:0]    a_yi_reg, a_yi_next;
    logic                 a_mode_reg;
    logic                 a_zero_reg, a_zero_next;

    // Stage B: fixed-point scaling and squares.
    logic                        b_valid_reg;
    logic signed [CORDIC_W-1:0]  b_xf_reg, b_xf_next;
    logic signed [CORDIC_W-1:0]  b_yf_reg, b_yf_next;
    logic [17:0]                 b_xsq_reg, b_xsq_next;
    logic [15:0]                 b_ysq_reg, b_ysq_next;
    logic                        b_mode_reg;
    logic                        b_zero_reg;

    // Stage C: token for the rotation pipeline.
    logic        c_valid_reg;
    psd_token_t  c_tok_reg, c_tok_next;

    logic signed [9:0]           sa, sb, sc, sd;
    logic signed [9:0]           yi_wide;
    logic signed [CORDIC_W-1:0]  xi_ext, yi_ext;
    logic signed [19:0]          xi_sq_op, xi_sq_full;
    logic signed [17:0]          yi_sq_op, yi_sq_full;
    logic [18:0]                 m2;
    logic                        x_neg;

    always_comb
    begin
        sa = signed'({2'b00, samples.sample_a});
        sb = signed'({2'b00, samples.sample_b});
        sc = signed'({2'b00, samples.sample_c});
        sd = signed'({2'b00, samples.sample_d});
        if (step_mode == MODE_FOUR_STEP)
        begin
            a_xi_next = sa - sc;
            yi_wide   = sb - sd;
        end
        else
        begin
            a_xi_next = (sa <<< 1) - sb - sc;
            yi_wide   = sb - sc;
        end
        a_yi_next   = signed'(yi_wide[8:0]);
        a_zero_next = (a_xi_next == '0) && (yi_wide == '0);
    end

    always_comb
    begin
        xi_ext     = CORDIC_W'(a_xi_reg);
        yi_ext     = CORDIC_W'(a_yi_reg);
        b_xf_next  = xi_ext <<< 16;
        if (a_mode_reg == MODE_FOUR_STEP)
        begin
            b_yf_next = yi_ext <<< 16;
        end
        else
        begin
            b_yf_next = yi_ext * SQRT3_Q16;
        end
        xi_sq_op   = 20'(a_xi_reg);
        xi_sq_full = xi_sq_op * xi_sq_op;
        yi_sq_op   = 18'(a_yi_reg);
        yi_sq_full = yi_sq_op * yi_sq_op;
        b_xsq_next = xi_sq_full[17:0];
        b_ysq_next = yi_sq_full[15:0];
    end

    always_comb
    begin
        if (b_mode_reg == MODE_FOUR_STEP)
        begin
            m2 = {1'b0, b_xsq_reg} + 19'(b_ysq_reg);
        end
        else
        begin
            m2 = {1'b0, b_xsq_reg} + 19'({b_ysq_reg, 1'b0}) + 19'(b_ysq_reg);
        end
        x_neg           = b_xf_reg[CORDIC_W-1];
        c_tok_next.x    = x_neg ? -b_xf_reg : b_xf_reg;
        c_tok_next.y    = x_neg ? -b_yf_reg : b_yf_reg;
        c_tok_next.ang  = x_neg ? ANG_HALF_TURN : '0;
        c_tok_next.rem  = m2[15:0];
        c_tok_next.root = '0;
        c_tok_next.sat  = (m2 > MAG_SAT_LIMIT);
        c_tok_next.zero = b_zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= sample_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_xi_reg   <= a_xi_next;
            a_yi_reg   <= a_yi_next;
            a_mode_reg <= step_mode;
            a_zero_reg <= a_zero_next;
            b_xf_reg   <= b_xf_next;
            b_yf_reg   <= b_yf_next;
            b_xsq_reg  <= b_xsq_next;
            b_ysq_reg  <= b_ysq_next;
            b_mode_reg <= a_mode_reg;
            b_zero_reg <= a_zero_reg;
            c_tok_reg  <= c_tok_next;
        end
    end

    assign tok_valid = c_valid_reg;
    assign tok       = c_tok_reg;

endmodule

@@ src/psd_cordic.sv @@
`timescale 1ns / 1ps
// Rotation pipeline: one CORDIC vectoring step per stage, with one root digit in the first stages.
module psd_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 head_valid,
    input  psd_pkg::psd_token_t  head,
    output logic                 tail_valid,
    output psd_pkg::psd_token_t  tail
);
    import psd_pkg::*;

    function automatic psd_token_t cordic_step(input psd_token_t t, input int idx);
        psd_token_t                  r;
        logic signed [CORDIC_W-1:0]  xo, yo, dx, dy;
        logic [16:0]                 bitv, trial;
        r  = t;
        xo = t.x;
        yo = t.y;
        dx = yo >>> idx;
        dy = xo >>> idx;
        if (!yo[CORDIC_W-1])
        begin
            r.x   = xo + dx;
            r.y   = yo - dy;
            r.ang = t.ang + atan_turn(5'(idx));
        end
        else
        begin
            r.x   = xo - dx;
            r.y   = yo + dy;
            r.ang = t.ang - atan_turn(5'(idx));
        end
        // Restoring square root, two radicand bits per stage.
        if (idx < SQRT_STEPS)
        begin
            bitv  = 17'd1 << (SQRT_TOP_BIT - 2 * idx);
            trial = t.root + bitv;
            if ({1'b0, t.rem} >= trial)
            begin
                r.rem  = t.rem - trial[15:0];
                r.root = (t.root >> 1) + bitv;
            end
            else
            begin
                r.root = t.root >> 1;
            end
        end
        return r;
    endfunction

    logic        stage_valid_reg [CORDIC_STEPS];
    psd_token_t  stage_tok_reg   [CORDIC_STEPS];
    logic        stage_in_valid  [CORDIC_STEPS];
    psd_token_t  stage_in_tok    [CORDIC_STEPS];
    psd_token_t  stage_tok_next  [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign stage_in_valid[k] = head_valid;
            assign stage_in_tok[k]   = head;
        end
        else
        begin : g_rest
            assign stage_in_valid[k] = stage_valid_reg[k-1];
            assign stage_in_tok[k]   = stage_tok_reg[k-1];
        end

        always_comb
        begin
            stage_tok_next[k] = cordic_step(stage_in_tok[k], k);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                stage_valid_reg[k] <= stage_in_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_tok_reg[k] <= stage_tok_next[k];
            end
        end
    end

    assign tail_valid = stage_valid_reg[CORDIC_STEPS-1];
    assign tail       = stage_tok_reg[CORDIC_STEPS-1];

endmodule

@@ src/psd_out.sv @@
`timescale 1ns / 1ps
// Result formatting with an output register and a skid register; the skid register sets the pipeline enable.
module psd_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tail_valid,
    input  psd_pkg::psd_token_t   tail,
    input  logic                  result_ready,
    output logic                  en,
    output logic                  result_valid,
    output psd_pkg::psd_result_t  result
);
    import psd_pkg::*;

    logic         out_valid_reg, out_valid_next;
    psd_result_t  out_data_reg, out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    psd_result_t  skid_data_reg, skid_data_next;

    psd_result_t            fmt;
    logic [31:0]            ang_rnd;
    logic [PHASE_BITS-1:0]  phase;
    logic [16:0]            root_rnd;
    logic                   push;
    logic                   out_free;

    always_comb
    begin
        ang_rnd  = tail.ang + PHASE_HALF_LSB;
        phase    = ang_rnd[31 -: PHASE_BITS];
        root_rnd = tail.root + 17'({1'b0, tail.rem} > tail.root);
        fmt.wrapped_phase = tail.zero ? '0 : 16'(phase);
        fmt.modulation    = tail.sat ? 8'hFF : root_rnd[7:0];
    end

    assign en       = !skid_valid_reg;
    assign push     = en && tail_valid;
    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : fmt;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = fmt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

@@ src/phase_shift_demodulator_core.sv @@
`timescale 1ns / 1ps
// Top level of the three- and four-step phase-shift demodulator.
//
// Each request on the sample channel carries one pixel seen in three or four
// phase-shifted fringe frames. Each request on the result channel carries that
// pixel's wrapped phase (a fraction of a turn) and its modulation magnitude,
// one result per sample, in order. Both channels use valid and ready.
// The step_mode register, written over the APB port, selects the three-step
// or the four-step formula; change it only while the block is empty.
// A result passes three front-end stages, thirty CORDIC stages and the
// output register. One sample is taken in every cycle while the skid
// register is empty; the CORDIC pipeline, one vectoring step per stage,
// makes up most of that depth.
// Reset clears all valid bits and step_mode (three-step) at once; no sweep.
// When the receiver stalls, the output register holds its result and one more
// result lands in a skid register. Only then does the whole pipeline freeze
// and sample_ready drop, so nothing is lost or repeated.
module phase_shift_demodulator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  psd_pkg::psd_sample_t          samples,
    output logic                          result_valid,
    input  logic                          result_ready,
    output psd_pkg::psd_result_t          result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import psd_pkg::*;

    logic        step_mode_reg, step_mode_next;
    logic        en;
    logic        front_valid;
    psd_token_t  front_tok;
    logic        tail_valid;
    psd_token_t  tail_tok;
    logic        reg_write;
    logic        reg_idx;

    // The single register sits at byte address zero; paddr bit 2 is the index.
    assign reg_idx   = paddr[PADDR_W-1];
    assign reg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        step_mode_next = step_mode_reg;
        if (reg_write && (reg_idx == REG_IDX_STEP_MODE))
        begin
            step_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_mode_reg <= MODE_THREE_STEP;
        end
        else
        begin
            step_mode_reg <= step_mode_next;
        end
    end

    // Reads outside the register map return zero.
    assign prdata = (reg_idx == REG_IDX_STEP_MODE) ? {31'd0, step_mode_reg} : 32'd0;

    // The pipeline moves as one whenever the skid register is empty.
    assign sample_ready = en;

    psd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .sample_valid (sample_valid),
        .samples      (samples),
        .step_mode    (step_mode_reg),
        .tok_valid    (front_valid),
        .tok          (front_tok)
    );

    psd_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .head_valid (front_valid),
        .head       (front_tok),
        .tail_valid (tail_valid),
        .tail       (tail_tok)
    );

    psd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .tail_valid   (tail_valid),
        .tail         (tail_tok),
        .result_ready (result_ready),
        .en           (en),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ tb/sv/tb_phase_shift_demodulator_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the phase-shift demodulator core: table-driven and random pixels.
module tb_phase_shift_demodulator_core;

    import psd_pkg::*;

    // Byte addresses on the APB port: register i sits at 4*i. The second
    // address maps to no register, so writes there must leave step_mode alone.
    localparam logic [PADDR_W-1:0] ADDR_STEP_MODE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_NO_REG    = 3'd4;

    // Pipeline depth from the head of the RTL, plus some slack for the tail wait.
    localparam int PIPE_LATENCY   = 34;
    localparam int RANDOM_PIXELS  = 1650;
    localparam int RANDOM_PHASES  = 6;
    localparam int IDLE_PERCENT   = 15;
    localparam int STEADY_FIRST   = 600;
    localparam int STEADY_LAST    = 899;
    localparam int REPORT_LIMIT   = 10;

    // Fixed-point scale of sqrt(3) used for the three-step quadrature term.
    localparam longint ROOT3_Q16 = 113512;

    // Arctangent of 2**-i as a fraction of a turn, in units of 2**-32.
    localparam logic [31:0] ATAN_TURN [30] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // One row of the directed table. When known is set the expected phase
    // and modulation are typed in; otherwise the predictor supplies them.
    typedef struct packed {
        logic        mode;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic        known;
        logic [15:0] phase;
        logic [7:0]  mag;
    } directed_row_t;

    localparam int NUM_DIRECTED = 23;

    localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
        // Three-step rows; the register comes out of reset in this mode.
        '{MODE_THREE_STEP, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd77,  8'd77,  8'd77,  8'd255, 1'b1, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd0,   8'd255, 8'd0,   8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd255, 8'd0,   8'd255, 8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd1,   8'd0,   8'd0,   8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd0,   8'd1,   8'd0,   8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_THREE_STEP, 8'd128, 8'd127, 8'd128, 8'd0,   1'b0, 16'd0, 8'd0},
        // Four-step rows.
        '{MODE_FOUR_STEP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd128, 8'd200, 8'd128, 8'd200, 1'b1, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd0,   8'd255, 8'd0,   8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd1,   8'd0,   8'd0,   8'd1,   1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd0,   8'd0,   8'd1,   8'd0,   1'b0, 16'd0, 8'd0},
        '{MODE_FOUR_STEP,  8'd200, 8'd3,   8'd20,  8'd2,   1'b0, 16'd0, 8'd0}
    };

    logic          clk;
    logic          rst_n;
    logic          sample_valid;
    logic          sample_ready;
    psd_sample_t   samples;
    logic          result_valid;
    logic          result_ready;
    psd_result_t   result;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Shadow copy of step_mode, kept in step with every APB write.
    logic          mode_shadow;

    // Results still owed by the block, oldest first.
    psd_result_t   owed_results[$];

    // While set, neither side inserts idle cycles.
    logic          steady_flow;

    int            error_count;
    int            results_checked;
    int            pixels_three_step;
    int            pixels_four_step;
    int            saturated_seen;

    phase_shift_demodulator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .samples      (samples),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Predicted phase and modulation for one pixel under the given mode.
    // The quadrature pair is scaled by 2**16 and rotated onto the positive
    // x axis by thirty vectoring steps; the accumulated angle, rounded to
    // 16 bits, is the wrapped phase. The modulation is the exact rounded
    // integer root of x*x + y*y, clipped to 8 bits.
    function automatic psd_result_t demod_pixel(input logic mode, input psd_sample_t px);
        int          xi;
        int          yi;
        int          m2;
        int          root;
        longint      xf;
        longint      yf;
        longint      dx;
        longint      dy;
        logic [31:0] ang;
        logic [32:0] rounded;
        psd_result_t res;
        if (mode == MODE_FOUR_STEP)
        begin
            xi = int'(px.sample_a) - int'(px.sample_c);
            yi = int'(px.sample_b) - int'(px.sample_d);
            xf = longint'(xi) * 65536;
            yf = longint'(yi) * 65536;
            m2 = xi * xi + yi * yi;
        end
        else
        begin
            xi = 2 * int'(px.sample_a) - int'(px.sample_b) - int'(px.sample_c);
            yi = int'(px.sample_b) - int'(px.sample_c);
            xf = longint'(xi) * 65536;
            yf = longint'(yi) * ROOT3_Q16;
            m2 = xi * xi + 3 * yi * yi;
        end

        if (xi == 0 && yi == 0)
        begin
            res.wrapped_phase = 16'd0;
        end
        else
        begin
            ang = 32'd0;
            // Left half plane: turn by half a turn first.
            if (xf < 0)
            begin
                xf = -xf;
                yf = -yf;
                ang = 32'h8000_0000;
            end
            for (int i = 0; i < 30; i++)
            begin
                dx = yf >>> i;
                dy = xf >>> i;
                if (yf >= 0)
                begin
                    xf = xf + dx;
                    yf = yf - dy;
                    ang = ang + ATAN_TURN[i];
                end
                else
                begin
                    xf = xf - dx;
                    yf = yf + dy;
                    ang = ang - ATAN_TURN[i];
                end
            end
            // Rounding just below a full turn carries out of bit 31 and
            // wraps the phase to zero.
            rounded = {1'b0, ang} + 33'h0_0000_8000;
            res.wrapped_phase = rounded[31:16];
        end

        root = 0;
        while ((root + 1) * (root + 1) <= m2)
            root++;
        if (m2 - root * root > root)
            root++;
        res.modulation = (root > 255) ? 8'd255 : 8'(root);
        return res;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // One APB transfer, entered and left at a falling edge. The transfer
    // completes at the rising edge of the access cycle where pready is high.
    task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
                                input logic [31:0] data, output logic [31:0] rd);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write a register, update the shadow the way the block should, then read
    // step_mode back. Only bit 0 of the written word counts, and a write to
    // an address with no register behind it changes nothing.
    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        logic [31:0] rd;
        apb_transfer(1'b1, addr, data, rd);
        if (addr == ADDR_STEP_MODE)
            mode_shadow = data[0];
        apb_transfer(1'b0, ADDR_STEP_MODE, 32'd0, rd);
        if (rd !== {31'd0, mode_shadow})
            flag_error($sformatf("step_mode read back %0h, expected %0h", rd, mode_shadow));
    endtask

    // Every request yields exactly one result, so the block is empty once
    // nothing is owed. Entered and left at a falling edge.
    task automatic drain_pipeline();
        sample_valid = 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
    endtask

    // Offer one pixel on the sample channel and wait for it to be taken.
    // Valid stays high after acceptance; the next call lowers it only if it
    // decides to idle, so back-to-back requests never drop valid.
    task automatic send_pixel(input psd_sample_t px, input logic known,
                              input psd_result_t typed_res);
        psd_result_t predicted;
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        samples      = px;
        sample_valid = 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        predicted = known ? typed_res : demod_pixel(mode_shadow, px);
        owed_results.push_back(predicted);
        if (mode_shadow == MODE_FOUR_STEP)
            pixels_four_step++;
        else
            pixels_three_step++;
        @(negedge clk);
    endtask

    // Random pixel: mostly uniform, with some near-equal samples that give
    // short vectors, some all-extreme pixels, and some tiny values.
    function automatic psd_sample_t random_pixel();
        psd_sample_t px;
        int          kind;
        int          base;
        int          v;
        kind = $urandom_range(9);
        px = psd_sample_t'($urandom);
        if (kind >= 6 && kind <= 7)
        begin
            base = $urandom_range(255);
            for (int k = 0; k < 4; k++)
            begin
                v = base + $urandom_range(6) - 3;
                v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                px[31 - 8 * k -: 8] = 8'(v);
            end
        end
        else if (kind == 8)
        begin
            for (int k = 0; k < 4; k++)
                px[31 - 8 * k -: 8] = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        else if (kind == 9)
        begin
            for (int k = 0; k < 4; k++)
                px[31 - 8 * k -: 8] = 8'($urandom_range(3));
        end
        return px;
    endfunction

    // Receiver: ready changes at the falling edge, idling at random unless
    // the steady stretch is on.
    always @(negedge clk)
        result_ready = steady_flow || ($urandom_range(99) >= IDLE_PERCENT);

    // Scoreboard: each accepted result is matched against the oldest owed one.
    always @(posedge clk)
    begin
        psd_result_t owed;
        if (rst_n && result_valid && result_ready)
        begin
            if (owed_results.size() == 0)
            begin
                flag_error($sformatf("result phase=%0d mod=%0d with no request pending",
                                     result.wrapped_phase, result.modulation));
            end
            else
            begin
                owed = owed_results.pop_front();
                results_checked++;
                if (owed.modulation == 8'd255)
                    saturated_seen++;
                if (result.wrapped_phase !== owed.wrapped_phase ||
                    result.modulation !== owed.modulation)
                    flag_error($sformatf("result %0d: phase %0d (exp %0d), mod %0d (exp %0d)",
                                         results_checked, result.wrapped_phase,
                                         owed.wrapped_phase, result.modulation,
                                         owed.modulation));
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        psd_sample_t px;
        psd_result_t typed_res;
        int          sent;
        logic        phase_mode;

        clk          = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        samples      = '0;
        result_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        steady_flow  = 1'b0;
        mode_shadow  = MODE_THREE_STEP;
        error_count  = 0;
        results_checked   = 0;
        pixels_three_step = 0;
        pixels_four_step  = 0;
        saturated_seen    = 0;
        sent = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table. The mode only changes between rows once the
        // pipeline has emptied.
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            if (DIRECTED[r].mode != mode_shadow)
            begin
                drain_pipeline();
                write_register(ADDR_STEP_MODE, {31'd0, DIRECTED[r].mode});
            end
            px = '{DIRECTED[r].a, DIRECTED[r].b, DIRECTED[r].c, DIRECTED[r].d};
            typed_res = '{DIRECTED[r].phase, DIRECTED[r].mag};
            send_pixel(px, DIRECTED[r].known, typed_res);
        end

        // A write to an unmapped address must be ignored, and a write with
        // bit 0 clear but every other bit set must select three-step mode.
        drain_pipeline();
        write_register(ADDR_NO_REG, 32'hFFFF_FFFF);
        write_register(ADDR_STEP_MODE, 32'hFFFF_FFFE);

        // Random phases alternate the mode, with junk in the upper data bits
        // and an occasional write to the unmapped address in between.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            phase_mode = p[0] ? MODE_THREE_STEP : MODE_FOUR_STEP;
            drain_pipeline();
            if ($urandom_range(1))
                write_register(ADDR_NO_REG, $urandom);
            write_register(ADDR_STEP_MODE,
                           {31'($urandom_range(32'h7FFF_FFFF)), phase_mode});
            for (int k = 0; k < RANDOM_PIXELS / RANDOM_PHASES; k++)
            begin
                steady_flow = (sent >= STEADY_FIRST && sent <= STEADY_LAST);
                send_pixel(random_pixel(), 1'b0, '0);
                sent++;
            end
        end
        steady_flow = 1'b0;

        drain_pipeline();
        // Give a stray extra result time to show up before judging the run.
        repeat (PIPE_LATENCY + 6) @(posedge clk);

        $display("Covered %0d three-step and %0d four-step pixels; %0d results checked.",
                 pixels_three_step, pixels_four_step, results_checked);
        $display("Saturated modulation predicted for %0d results; %0d errors found.",
                 saturated_seen, error_count);
        if (error_count == 0 && owed_results.size() == 0)
            $display("tb_phase_shift_demodulator_core: done, clean");
        else
            $display("tb_phase_shift_demodulator_core: done, errors");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results still owed.", owed_results.size());
        $display("tb_phase_shift_demodulator_core: done, errors");
        $finish;
    end

endmodule
